>>> rtl/gac_pkg.sv
// ----------------------------------------------------------------------------
// gac_pkg: shared types and constants of the Gronsfeld cipher core
// Field widths, function, status and register codes, and the result type.
// ----------------------------------------------------------------------------
package gac_pkg;

   // Parameter defaults
   localparam int ALPHABET_MAX_DEF = 256;
   localparam int KEY_MAX_DEF      = 64;

   // Field widths
   localparam int FUNC_W      = 3;
   localparam int SLOT_W      = 8;
   localparam int CHAR_W      = 8;
   localparam int STATUS_W    = 2;
   localparam int SIZE_W      = 9;
   localparam int KEYLEN_W    = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;
   localparam int DIGIT_W     = 4;
   localparam int BYTE_VALUES = 256;
   // Wide enough for any count up to 256
   localparam int COUNT_W     = 9;

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD_ALPHA = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_KEY   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_ENCRYPT    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DECRYPT    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_RESTART    = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_KEY   = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHABET_SIZE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH    = 1'd1;

   // Register reset values
   localparam logic [SIZE_W-1:0]   SIZE_RESET   = 9'd256;
   localparam logic [KEYLEN_W-1:0] KEYLEN_RESET = 7'd1;

   // Key digit characters
   localparam logic [CHAR_W-1:0]  DIGIT_ZERO = 8'd48;
   localparam logic [CHAR_W-1:0]  DIGIT_NINE = DIGIT_ZERO + 8'd9;
   localparam logic [DIGIT_W-1:0] BAD_DIGIT  = 4'd15;

   // Result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef struct packed {
      logic [CHAR_W-1:0]   out_char;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

>>> rtl/gronsfeld_alphabet_cipher_core.sv
// ----------------------------------------------------------------------------
// gronsfeld_alphabet_cipher_core: Gronsfeld cipher over a loadable alphabet
// Digit-key shift cipher; alphabet, reverse map and key live in memories.
// ----------------------------------------------------------------------------
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------
//   request  | req_valid / req_ready  | req_func, req_slot, req_value
//   response | rsp_valid / rsp_ready  | rsp_out_char, rsp_status
//   control  | csr_we (no wait)       | csr_index, csr_wdata
//
// Cycles: one request beat per cycle while req_ready is high. A response beat
// follows its request beat through the reverse map read, the alphabet read
// and the result queue.
// Reset: clears the reverse map's valid flags at once (no sweep), the key
// position, the registers and the result queue.
// Stalls: up to four results queue behind rsp_ready; req_ready drops when
// queued plus in-flight results reach four.
// ----------------------------------------------------------------------------
module gronsfeld_alphabet_cipher_core #(
   parameter int ALPHABET_MAX = gac_pkg::ALPHABET_MAX_DEF,
   parameter int KEY_MAX      = gac_pkg::KEY_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gac_pkg::FUNC_W-1:0]        req_func,
   input  logic [gac_pkg::SLOT_W-1:0]        req_slot,
   input  logic [gac_pkg::CHAR_W-1:0]        req_value,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gac_pkg::CHAR_W-1:0]        rsp_out_char,
   output logic [gac_pkg::STATUS_W-1:0]      rsp_status,
   // control registers
   input  logic                              csr_we,
   input  logic [gac_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gac_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gac_pkg::*;

   localparam int AW = $clog2(ALPHABET_MAX);
   localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam logic [COUNT_W-1:0] AMAX = COUNT_W'(ALPHABET_MAX);
   localparam logic [COUNT_W-1:0] KMAX = COUNT_W'(KEY_MAX);

   // ------------------------------------------------------------------
   // Storage
   // ------------------------------------------------------------------
   logic [CHAR_W-1:0]    alph_mem [ALPHABET_MAX];   // alphabet entries
   logic [AW-1:0]        rmap_mem [BYTE_VALUES];    // byte -> lowest slot
   logic [DIGIT_W-1:0]   key_mem  [KEY_MAX];        // key digits
   logic [BYTE_VALUES-1:0] rmap_vld_ff;             // reverse map valid flags

   // Control registers and key position
   logic [SIZE_W-1:0]    size_ff;
   logic [KEYLEN_W-1:0]  keylen_ff;
   logic [KW-1:0]        keypos_ff, keypos_in;

   // Memory read data
   logic [AW-1:0]        rmap_q_ff;
   logic [DIGIT_W-1:0]   key_q_ff;
   logic [CHAR_W-1:0]    alph_pos_ff;
   logic [CHAR_W-1:0]    alph_idx_ff;

   // Last reverse map write, for forwarding into the next item's lookup
   logic                 lw_vld_ff;
   logic [CHAR_W-1:0]    lw_ch_ff;
   logic [AW-1:0]        lw_slot_ff;

   // Stage 1: lookup results arrive, indexes are formed
   logic                 v1_ff, text1_ff, dec1_ff, alpha1_ff, keybad1_ff;
   logic [CHAR_W-1:0]    ch1_ff;
   logic [AW-1:0]        slot1_ff;

   // Stage 2: alphabet data arrives, result is formed
   logic                 v2_ff, text2_ff, keybad2_ff, found2_ff, bad2_ff;
   logic [CHAR_W-1:0]    ch2_ff;

   // ------------------------------------------------------------------
   // Stage 0: accept, key position and stores written directly
   // ------------------------------------------------------------------
   logic                 accept;
   logic                 text0, alpha_wr0, key_wr0, digit_ok0;
   logic [DIGIT_W-1:0]   digit0;
   logic [COUNT_W-1:0]   klen_sat, klen_eff, kp_next;
   logic [RSP_CNT_W:0]   pending;
   logic [RSP_CNT_W-1:0] q_count;

   assign accept    = req_valid && req_ready;
   assign text0     = (req_func == FUNC_ENCRYPT) || (req_func == FUNC_DECRYPT);
   assign alpha_wr0 = (req_func == FUNC_LOAD_ALPHA) && ({1'b0, req_slot} < AMAX);
   assign key_wr0   = (req_func == FUNC_LOAD_KEY) && ({1'b0, req_slot} < KMAX);
   assign digit_ok0 = (req_value >= DIGIT_ZERO) && (req_value <= DIGIT_NINE);
   assign digit0    = digit_ok0 ? DIGIT_W'(req_value - DIGIT_ZERO) : BAD_DIGIT;

   // Saturate the key length, treat zero as one, wrap the position
   always_comb begin
      klen_sat  = ({2'b0, keylen_ff} > KMAX) ? KMAX : {2'b0, keylen_ff};
      klen_eff  = (klen_sat == '0) ? COUNT_W'(1) : klen_sat;
      kp_next   = COUNT_W'(keypos_ff) + 1'b1;
      keypos_in = keypos_ff;
      if (accept && text0) begin
         keypos_in = (kp_next >= klen_eff) ? '0 : kp_next[KW-1:0];
      end else if (accept && (req_func == FUNC_RESTART)) begin
         keypos_in = '0;
      end
   end

   // Hold off new beats while the queue could not take every result in flight
   assign pending   = {1'b0, q_count} + (RSP_CNT_W+1)'(v1_ff) + (RSP_CNT_W+1)'(v2_ff);
   assign req_ready = (pending < (RSP_CNT_W+1)'(RSP_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= SIZE_RESET;
         keylen_ff <= KEYLEN_RESET;
         keypos_ff <= '0;
      end else begin
         keypos_ff <= keypos_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ALPHABET_SIZE: size_ff   <= csr_wdata[SIZE_W-1:0];
               CSR_KEY_LENGTH:    keylen_ff <= csr_wdata[KEYLEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Key store: write on accept, read the current position every cycle
   always_ff @(posedge clock) begin
      if (accept && key_wr0) begin
         key_mem[req_slot[KW-1:0]] <= digit0;
      end
      key_q_ff <= key_mem[keypos_ff];
   end

   // ------------------------------------------------------------------
   // Stage 1: reverse map entry (with forwarding), shift, target index
   // ------------------------------------------------------------------
   logic                 fwd1, cur_vld1, rmap_we;
   logic [AW-1:0]        cur_slot1;
   logic [COUNT_W-1:0]   size_eff, pos9, shift9, sum9, idx9;
   logic                 found1, bad1;
   logic [AW-1:0]        idx1;

   always_comb begin
      fwd1      = lw_vld_ff && (lw_ch_ff == ch1_ff);
      cur_vld1  = rmap_vld_ff[ch1_ff];
      cur_slot1 = fwd1 ? lw_slot_ff : rmap_q_ff;
      // Keep the lowest slot ever loaded with this byte
      rmap_we   = v1_ff && alpha1_ff && (!cur_vld1 || (slot1_ff < cur_slot1));

      size_eff  = ({1'b0, size_ff[SIZE_W-2:0]} > AMAX || size_ff[SIZE_W-1])
                  ? ((COUNT_W'(size_ff) > AMAX) ? AMAX : COUNT_W'(size_ff))
                  : COUNT_W'(size_ff);
      pos9      = COUNT_W'(cur_slot1);
      shift9    = COUNT_W'(key_q_ff);
      found1    = cur_vld1 && (pos9 < size_eff);
      bad1      = (key_q_ff == BAD_DIGIT) || (shift9 >= size_eff);

      if (dec1_ff) begin
         idx9 = (pos9 >= shift9) ? pos9 - shift9 : pos9 + size_eff - shift9;
         sum9 = '0;
      end else begin
         sum9 = pos9 + shift9;
         idx9 = (sum9 >= size_eff) ? sum9 - size_eff : sum9;
      end
      idx1 = idx9[AW-1:0];
   end

   // Reverse map: read the accepted byte, write back from stage 1
   always_ff @(posedge clock) begin
      if (rmap_we) begin
         rmap_mem[ch1_ff] <= slot1_ff;
      end
      rmap_q_ff <= rmap_mem[req_value];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rmap_vld_ff <= '0;
         lw_vld_ff   <= 1'b0;
      end else begin
         lw_vld_ff <= rmap_we;
         if (rmap_we) begin
            rmap_vld_ff[ch1_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      lw_ch_ff   <= ch1_ff;
      lw_slot_ff <= slot1_ff;
   end

   // Alphabet: write on accept, read both the looked-up and target slots
   always_ff @(posedge clock) begin
      if (accept && alpha_wr0) begin
         alph_mem[req_slot[AW-1:0]] <= req_value;
      end
      alph_pos_ff <= alph_mem[cur_slot1];
      alph_idx_ff <= alph_mem[idx1];
   end

   // ------------------------------------------------------------------
   // Pipeline registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      text1_ff   <= text0;
      dec1_ff    <= (req_func == FUNC_DECRYPT);
      alpha1_ff  <= alpha_wr0;
      keybad1_ff <= (req_func == FUNC_LOAD_KEY) && !digit_ok0;
      ch1_ff     <= req_value;
      slot1_ff   <= req_slot[AW-1:0];

      text2_ff   <= text1_ff;
      keybad2_ff <= keybad1_ff;
      found2_ff  <= found1;
      bad2_ff    <= bad1;
      ch2_ff     <= ch1_ff;
   end

   // ------------------------------------------------------------------
   // Stage 2: confirm the slot still holds the byte, form the result
   // ------------------------------------------------------------------
   rsp_type res2, q_data;
   logic    found2;

   always_comb begin
      found2        = found2_ff && (alph_pos_ff == ch2_ff);
      res2.out_char = '0;
      res2.status   = STATUS_OK;
      if (text2_ff) begin
         if (!found2) begin
            res2.status = STATUS_NOT_FOUND;
         end else if (bad2_ff) begin
            res2.status = STATUS_BAD_KEY;
         end else begin
            res2.out_char = alph_idx_ff;
         end
      end else if (keybad2_ff) begin
         res2.status = STATUS_BAD_KEY;
      end
   end

   gac_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (v2_ff),
      .push_data  (res2),
      .pop_ready  (rsp_ready),
      .pop_valid  (rsp_valid),
      .pop_data   (q_data),
      .count      (q_count)
   );

   assign rsp_out_char = q_data.out_char;
   assign rsp_status   = q_data.status;

endmodule

>>> rtl/gac_rsp_queue.sv
// ----------------------------------------------------------------------------
// gac_rsp_queue: result queue of the Gronsfeld cipher core
// Small FIFO of finished results; the core never pushes into a full queue.
// ----------------------------------------------------------------------------
module gac_rsp_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push_valid,
   input  gac_pkg::rsp_type               push_data,
   input  logic                           pop_ready,
   output logic                           pop_valid,
   output gac_pkg::rsp_type               pop_data,
   output logic [gac_pkg::RSP_CNT_W-1:0]  count
);
   import gac_pkg::*;

   rsp_type                entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/gac_checker.sv
// ----------------------------------------------------------------------------
// gac_checker: port-level checks of the Gronsfeld cipher core
// Watches beat counts, result hold, flagged results and latency.
// ----------------------------------------------------------------------------
module gac_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [gac_pkg::CHAR_W-1:0]        rsp_out_char,
   input logic [gac_pkg::STATUS_W-1:0]      rsp_status
);
   import gac_pkg::*;

   logic                 req_beat, rsp_beat;
   logic [RSP_CNT_W:0]   outst_ff;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // Request beats not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_ff + (RSP_CNT_W+1)'(req_beat) - (RSP_CNT_W+1)'(rsp_beat);
      end
   end

   a_outst_bound: assert property (@(posedge clock) disable iff (reset)
      outst_ff <= (RSP_CNT_W+1)'(RSP_DEPTH))
      else $error("more beats in flight than the result queue holds");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> (outst_ff != '0))
      else $error("response beat without an open request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_status))
      else $error("stalled response changed");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_out_char == '0))
      else $error("flagged response carries a character");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_beat && (outst_ff == '0) |-> ##3 rsp_valid)
      else $error("response missing three cycles after an idle request");

endmodule

bind gronsfeld_alphabet_cipher_core gac_checker u_gac_checker (.*);

>>> tb/sv/gronsfeld_cipher_checker.sv
// ----------------------------------------------------------------------------
// gronsfeld_cipher_checker: response predictor and comparator
// Tracks the cipher state from request and register beats and checks every
// response beat, field by field, against the oldest predicted result.
// ----------------------------------------------------------------------------
module gronsfeld_cipher_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [gac_pkg::FUNC_W-1:0]      req_func,
   input  logic [gac_pkg::SLOT_W-1:0]      req_slot,
   input  logic [gac_pkg::CHAR_W-1:0]      req_value,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [gac_pkg::CHAR_W-1:0]      rsp_out_char,
   input  logic [gac_pkg::STATUS_W-1:0]    rsp_status,
   input  logic                            csr_we,
   input  logic [gac_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gac_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              pending,
   output int                              checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import gac_pkg::*;

   localparam int ALPHA_SLOTS = ALPHABET_MAX_DEF;
   localparam int KEY_SLOTS   = KEY_MAX_DEF;
   localparam int MAX_REPORTS = 30;

   logic [CHAR_W-1:0]   alpha_tab [ALPHA_SLOTS];
   logic                map_valid [BYTE_VALUES];
   logic [COUNT_W-1:0]  map_slot  [BYTE_VALUES];
   logic [DIGIT_W-1:0]  key_tab   [KEY_SLOTS];
   int unsigned         key_pos;
   logic [SIZE_W-1:0]   size_reg;
   logic [KEYLEN_W-1:0] keylen_reg;
   rsp_type             cipher_results_q [$];
   int                  reports;

   function automatic void flag_mismatch(input string field, input int want, input int got);
      fail_count++;
      if (reports < MAX_REPORTS) begin
         reports++;
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
      end
   endfunction

   // Advance the cipher state by one request beat and return its result.
   function automatic rsp_type cipher_step(input logic [FUNC_W-1:0] f,
                                           input logic [SLOT_W-1:0] s,
                                           input logic [CHAR_W-1:0] ch);
      rsp_type           r;
      int unsigned       size_eff;
      int unsigned       klen_eff;
      int unsigned       shift;
      int unsigned       pos;
      int unsigned       idx;
      logic [CHAR_W-1:0] diff;
      logic [DIGIT_W-1:0] digit;
      bit                found;
      r.out_char = '0;
      r.status   = STATUS_OK;
      size_eff   = (size_reg > ALPHA_SLOTS) ? ALPHA_SLOTS : 32'(size_reg);
      klen_eff   = (keylen_reg > KEY_SLOTS) ? KEY_SLOTS : 32'(keylen_reg);
      if (klen_eff == 0) klen_eff = 1;
      case (f)
         FUNC_LOAD_ALPHA: begin
            if (s < ALPHA_SLOTS) begin
               alpha_tab[s] = ch;
               // the lowest slot ever loaded with a byte owns it
               if (!map_valid[ch] || s < map_slot[ch]) begin
                  map_valid[ch] = 1'b1;
                  map_slot[ch]  = COUNT_W'(s);
               end
            end
         end
         FUNC_LOAD_KEY: begin
            diff  = ch - DIGIT_ZERO;
            digit = (ch >= DIGIT_ZERO && ch <= DIGIT_NINE) ? diff[DIGIT_W-1:0] : BAD_DIGIT;
            if (s < KEY_SLOTS) key_tab[s] = digit;
            if (digit == BAD_DIGIT) r.status = STATUS_BAD_KEY;
         end
         FUNC_ENCRYPT, FUNC_DECRYPT: begin
            shift = 32'(key_tab[key_pos % KEY_SLOTS]);
            pos   = 32'(map_slot[ch]);
            found = map_valid[ch] && pos < size_eff && alpha_tab[pos % ALPHA_SLOTS] == ch;
            if (!found) begin
               r.status = STATUS_NOT_FOUND;
            end else if (shift == BAD_DIGIT || shift >= size_eff) begin
               r.status = STATUS_BAD_KEY;
            end else begin
               if (f == FUNC_ENCRYPT) begin
                  idx = pos + shift;
                  if (idx >= size_eff) idx -= size_eff;
               end else begin
                  idx = (pos >= shift) ? pos - shift : pos + size_eff - shift;
               end
               r.out_char = alpha_tab[idx % ALPHA_SLOTS];
            end
            // flagged text still moves the key along
            key_pos = (key_pos + 1 >= klen_eff) ? 0 : key_pos + 1;
         end
         FUNC_RESTART: key_pos = 0;
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < BYTE_VALUES; i++) begin
            map_valid[i] = 1'b0;
            map_slot[i]  = '0;
            alpha_tab[i] = '0;
         end
         for (int i = 0; i < KEY_SLOTS; i++) key_tab[i] = '0;
         key_pos    = 0;
         size_reg   = SIZE_RESET;
         keylen_reg = KEYLEN_RESET;
         cipher_results_q.delete();
      end else begin
         // compare first: a request beat in this cycle cannot answer yet
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (cipher_results_q.size() == 0) begin
               fail_count++;
               if (reports < MAX_REPORTS) begin
                  reports++;
                  $error("response beat with no result pending: char %0d status %0d",
                         rsp_out_char, rsp_status);
               end
            end else begin
               want = cipher_results_q.pop_front();
               if (rsp_out_char !== want.out_char)
                  flag_mismatch("out_char", want.out_char, rsp_out_char);
               if (rsp_status !== want.status)
                  flag_mismatch("status", want.status, rsp_status);
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_ALPHABET_SIZE) size_reg = csr_wdata[SIZE_W-1:0];
            else if (csr_index == CSR_KEY_LENGTH) keylen_reg = csr_wdata[KEYLEN_W-1:0];
         end
         if (req_valid && req_ready)
            cipher_results_q.push_back(cipher_step(req_func, req_slot, req_value));
      end
      pending = cipher_results_q.size();
   end

endmodule

>>> tb/sv/tb_gronsfeld_alphabet_cipher_core.sv
// ----------------------------------------------------------------------------
// tb_gronsfeld_alphabet_cipher_core: stimulus and verdict for the cipher core
// Loads an alphabet and key, runs directed corner cases, then random traffic
// over several register settings and pacing modes; a checker compares results.
// ----------------------------------------------------------------------------
module tb_gronsfeld_alphabet_cipher_core;
   timeunit 1ns;
   timeprecision 1ps;

   import gac_pkg::*;

   localparam int CLK_HALF        = 5;
   localparam int RESET_CYCLES    = 7;
   // watchdog limit on simulated cycles, with plenty of room on top
   localparam int CYCLE_LIMIT     = 200000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 95;
   localparam int LONG_HOLD       = 300;
   // pad a little after the last response so the pipeline settles
   localparam int DRAIN_CYCLES    = 6;

   // func codes with no meaning in the core
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

   // alphabet fill: slot i holds i ^ SCRAMBLE, except the last slot repeats
   // slot DUP_SLOT, so one byte never appears
   localparam logic [CHAR_W-1:0] ALPHA_SCRAMBLE = 8'hA5;
   localparam int                DUP_SLOT       = 3;
   localparam logic [CHAR_W-1:0] MISSING_BYTE   = 8'hFF ^ ALPHA_SCRAMBLE;
   localparam int                MARKER_SLOT    = 5;
   localparam logic [CHAR_W-1:0] BAD_KEY_CHAR   = 8'h78;
   localparam int                OVERWRITE_SLOT = 10;

   typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_type;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [FUNC_W-1:0]      req_func  = '0;
   logic [SLOT_W-1:0]      req_slot  = '0;
   logic [CHAR_W-1:0]      req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CHAR_W-1:0]      rsp_out_char;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int fail_count;
   int pending;
   int checked;

   // stimulus bookkeeping: what the alphabet holds, to aim text at it
   logic [CHAR_W-1:0] alpha_shadow [BYTE_VALUES];
   int size_eff_shadow = 256;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_requests;
   int hold_served;
   int hold_left;
   int cycle_count;
   int n_text, n_alpha, n_key, n_other;

   gronsfeld_alphabet_cipher_core uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_slot     (req_slot),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_status   (rsp_status),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   gronsfeld_cipher_checker cipher_watch (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_slot     (req_slot),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_status   (rsp_status),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending      (pending),
      .checked      (checked)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Watchdog: end the run if the core stops making progress.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Response side. A long hold-off is requested by the stimulus and timed
   // here, so the sender keeps offering beats while the core backs up.
   always @(negedge clock) begin
      if (hold_left == 0 && hold_served != hold_requests) begin
         hold_served++;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic set_pace(input pace_type m);
      case (m)
         PACE_FULL:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         PACE_SEND_IDLE:  begin send_idle_pct = 80; recv_stall_pct = 0;  end
         PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 80; end
         default:         begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
   endtask

   // Present one request beat from a falling edge and hold it until taken.
   // Valid stays high across back-to-back beats; it drops only while idling.
   task automatic send_item(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
                            input logic [CHAR_W-1:0] v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_slot  <= s;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      case (f)
         FUNC_LOAD_ALPHA: begin
            alpha_shadow[s] = v;
            n_alpha++;
         end
         FUNC_LOAD_KEY:               n_key++;
         FUNC_ENCRYPT, FUNC_DECRYPT:  n_text++;
         default:                     n_other++;
      endcase
   endtask

   // Stop offering beats until every predicted result has come back, then
   // let the pipeline settle so register writes land on an idle core.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Mostly text built from bytes the alphabet holds, with loads, restarts,
   // stray bytes and unused codes mixed in.
   task automatic send_random_item();
      int                pick;
      int                top_slot;
      int                max_digit;
      logic [FUNC_W-1:0] f;
      logic [SLOT_W-1:0] s;
      logic [CHAR_W-1:0] v;
      logic [CHAR_W-1:0] digit;
      pick      = $urandom_range(0, 99);
      top_slot  = (size_eff_shadow > 0) ? size_eff_shadow - 1 : BYTE_VALUES - 1;
      max_digit = (top_slot < 9) ? top_slot : 9;
      f = ($urandom_range(0, 1) == 0) ? FUNC_ENCRYPT : FUNC_DECRYPT;
      s = SLOT_W'($urandom_range(0, 255));
      v = CHAR_W'($urandom_range(0, 255));
      if (pick < 62) begin
         v = alpha_shadow[$urandom_range(0, top_slot)];
      end else if (pick < 72) begin
         // keep the stray byte
      end else if (pick < 81) begin
         f = FUNC_LOAD_ALPHA;
         if ($urandom_range(0, 1) == 0) s = SLOT_W'($urandom_range(0, top_slot));
      end else if (pick < 91) begin
         f = FUNC_LOAD_KEY;
         if ($urandom_range(0, 4) != 0) s = SLOT_W'($urandom_range(0, KEY_MAX_DEF - 1));
         if ($urandom_range(0, 4) != 0) begin
            // mostly shifts the current size allows, sometimes any digit
            digit = ($urandom_range(0, 4) != 0) ? CHAR_W'($urandom_range(0, max_digit))
                                                : CHAR_W'($urandom_range(0, 9));
            v = DIGIT_ZERO + digit;
         end
      end else if (pick < 96) begin
         f = FUNC_RESTART;
      end else begin
         f = FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
      end
      send_item(f, s, v);
   endtask

   initial begin
      int                p;
      int                sz;
      int                kl;
      bit                hold_off;
      pace_type          m;
      logic [CHAR_W-1:0] old_byte;
      logic [CHAR_W-1:0] key_char;

      set_pace(PACE_BOTH);
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Beats that touch no alphabet entry: unused codes, restart, key loads
      // that are ignored or flagged.
      send_item(FUNC_UNUSED_LO, 8'hFF, 8'hFF);
      send_item(FUNC_UNUSED_LO + 3'd1, 8'h00, 8'h00);
      send_item(FUNC_UNUSED_HI, 8'h5A, 8'hA5);
      send_item(FUNC_RESTART, 8'hFF, 8'h00);
      send_item(FUNC_LOAD_KEY, 8'hFF, 8'hFF);               // slot ignored, bad digit
      send_item(FUNC_LOAD_KEY, SLOT_W'(KEY_MAX_DEF), DIGIT_ZERO + 8'd3); // slot ignored
      send_item(FUNC_LOAD_KEY, SLOT_W'(KEY_MAX_DEF - 1), DIGIT_ZERO - 8'd1);
      send_item(FUNC_LOAD_KEY, SLOT_W'(KEY_MAX_DEF - 2), DIGIT_NINE + 8'd1);

      // Fill every alphabet and key entry so no later lookup hits an
      // unwritten one.
      for (int i = 0; i < BYTE_VALUES; i++)
         send_item(FUNC_LOAD_ALPHA, SLOT_W'(i),
                   CHAR_W'((i == BYTE_VALUES - 1) ? (DUP_SLOT ^ ALPHA_SCRAMBLE)
                                                  : (i ^ ALPHA_SCRAMBLE)));
      for (int i = 0; i < KEY_MAX_DEF; i++) begin
         key_char = DIGIT_ZERO + CHAR_W'(i % 10);
         send_item(FUNC_LOAD_KEY, SLOT_W'(i), (i == MARKER_SLOT) ? BAD_KEY_CHAR : key_char);
      end

      // Key of six so the bad-digit marker comes around.
      drain();
      write_reg(CSR_KEY_LENGTH, CSR_DATA_W'(MARKER_SLOT + 1));
      csr_we <= 1'b0;

      send_item(FUNC_RESTART, 8'h00, 8'h00);
      send_item(FUNC_ENCRYPT, 8'h00, alpha_shadow[0]);                  // zero shift
      send_item(FUNC_DECRYPT, 8'hFF, alpha_shadow[0]);                  // wraps below 0
      send_item(FUNC_ENCRYPT, 8'h80, alpha_shadow[BYTE_VALUES - 2]);    // wraps past top
      send_item(FUNC_ENCRYPT, 8'h01, MISSING_BYTE);                     // not in alphabet
      send_item(FUNC_DECRYPT, 8'h7F, alpha_shadow[BYTE_VALUES - 1]);    // duplicate byte
      send_item(FUNC_ENCRYPT, 8'h00, alpha_shadow[100]);                // marker digit
      send_item(FUNC_ENCRYPT, 8'h00, alpha_shadow[7]);                  // key wrapped
      old_byte = alpha_shadow[OVERWRITE_SLOT];
      send_item(FUNC_LOAD_ALPHA, SLOT_W'(OVERWRITE_SLOT), MISSING_BYTE);
      send_item(FUNC_ENCRYPT, 8'h00, old_byte);                         // overwritten
      send_item(FUNC_ENCRYPT, 8'h00, MISSING_BYTE);                     // now present
      send_item(FUNC_LOAD_KEY, 8'h00, DIGIT_NINE);
      send_item(FUNC_RESTART, 8'h00, 8'h00);
      send_item(FUNC_DECRYPT, 8'h00, alpha_shadow[0]);                  // shift nine

      // Random phases. Each sets both registers on an idle core; sizes and
      // key lengths sweep the extremes, including values that saturate.
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0:       begin sz = 256; kl = 7;   m = PACE_FULL;       hold_off = 1; end
            1:       begin sz = 5;   kl = 3;   m = PACE_SEND_IDLE;  hold_off = 0; end
            2:       begin sz = 1;   kl = 64;  m = PACE_RECV_STALL; hold_off = 0; end
            3:       begin sz = 26;  kl = 127; m = PACE_BOTH;       hold_off = 0; end
            4:       begin sz = 0;   kl = 0;   m = PACE_FULL;       hold_off = 1; end
            5:       begin sz = 511; kl = 10;  m = PACE_SEND_IDLE;  hold_off = 0; end
            6:       begin sz = 2;   kl = 1;   m = PACE_RECV_STALL; hold_off = 0; end
            default: begin sz = 200; kl = 448; m = PACE_BOTH;       hold_off = 0; end
         endcase
         drain();
         write_reg(CSR_ALPHABET_SIZE, CSR_DATA_W'(sz));
         write_reg(CSR_KEY_LENGTH, CSR_DATA_W'(kl));
         csr_we <= 1'b0;
         size_eff_shadow = (sz > BYTE_VALUES) ? BYTE_VALUES : sz;
         set_pace(m);
         if (hold_off) hold_requests++;
         repeat (ITEMS_PER_PHASE) send_random_item();
      end

      drain();
      $display("Drove %0d request beats: %0d text, %0d alphabet loads, %0d key loads, %0d other.",
               n_text + n_alpha + n_key + n_other, n_text, n_alpha, n_key, n_other);
      $display("Checked %0d response beats over %0d register settings and four pacing modes.",
               checked, PHASES + 1);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
